/* rtl/mexp_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// mexp_pkg
// Shared types and constants of the modular exponentiation block: operand
// widths, register indexes, controller states and the command/status bundles.
// ============================================================================
package mexp_pkg;

    // operand and port widths
    localparam int WORD_W     = 64;
    localparam int HALF_W     = 32;
    localparam int EXP_W      = 63;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 1;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_MODULUS      = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_MODULAR_MODE = 1'b1;

    // remainder unit: quotient bits retired per cycle
    localparam int DIV_STEPS  = 4;
    localparam int DIV_CYCLES = WORD_W / DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);
    localparam logic [DIV_CNT_W-1:0] DIV_CNT_LAST = DIV_CNT_W'(DIV_CYCLES - 1);

    // partial product phases of the 64 x 64 low-half product
    localparam int MUL_CNT_W = 2;
    localparam logic [MUL_CNT_W-1:0] MUL_PH_LL = 2'd0;  // a_lo * b_lo
    localparam logic [MUL_CNT_W-1:0] MUL_PH_LH = 2'd1;  // a_lo * b_hi
    localparam logic [MUL_CNT_W-1:0] MUL_PH_HL = 2'd2;  // a_hi * b_lo

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_BASE_RED,
        ST_TEST,
        ST_MUL,
        ST_MUL_RED,
        ST_SQR,
        ST_SQR_RED,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;           // capture operands, accumulator to one
        logic acc_zero;       // accumulator to zero
        logic mul_start;      // start a product
        logic mul_sqr;        // product is base * base, else acc * base
        logic div_start;      // start a reduction
        logic div_from_prod;  // reduce the product, else the base
        logic acc_wr;         // write accumulator
        logic base_wr;        // write base
        logic wr_from_rem;    // write source is the remainder, else the product
        logic exp_shift;      // drop the exponent's low bit
        logic out_load;       // load the result register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic exp_zero;
        logic exp_lsb;
        logic exp_rest_zero;
        logic mod_trivial;    // modulus of zero or one
        logic modular;
        logic mul_done;
        logic div_done;
    } status_t;

endpackage

/* rtl/mexp_dp.sv */
`timescale 1ns / 1ps
// ============================================================================
// mexp_dp
// Datapath: operand registers, a shared 32 x 32 multiplier that builds 64-bit
// products over phases, and a radix-16 restoring remainder unit.
// ============================================================================
module mexp_dp import mexp_pkg::*; #(
    parameter int MODULUS_BITS = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cmd_t                    cmd,
    output status_t                 status,
    input  logic [WORD_W-1:0]       in_base,
    input  logic [EXP_W-1:0]        in_exp,
    input  logic [MODULUS_BITS-1:0] modulus,
    input  logic                    modular_mode,
    output logic [WORD_W-1:0]       power
);

    logic [WORD_W-1:0]       base_reg;
    logic [WORD_W-1:0]       acc_reg;
    logic [EXP_W-1:0]        exp_reg;
    logic [WORD_W-1:0]       prod_reg;
    logic [WORD_W-1:0]       pp_reg;
    logic                    pp_shift_reg;
    logic                    pp_last_reg;
    logic                    pp_valid_reg;
    logic                    mul_busy_reg;
    logic                    mul_sqr_reg;
    logic [MUL_CNT_W-1:0]    mul_cnt_reg;
    logic                    mul_done_reg;
    logic [WORD_W-1:0]       div_num_reg;
    logic [MODULUS_BITS-1:0] div_rem_reg;
    logic [DIV_CNT_W-1:0]    div_cnt_reg;
    logic                    div_busy_reg;
    logic                    div_done_reg;
    logic [WORD_W-1:0]       power_reg;

    logic [WORD_W-1:0]       mul_a;
    logic [HALF_W-1:0]       mul_x;
    logic [HALF_W-1:0]       mul_y;
    logic                    mul_last;
    logic [WORD_W-1:0]       pp_add;
    logic [MODULUS_BITS-1:0] rem_step [DIV_STEPS+1];
    logic [MODULUS_BITS:0]   trial    [DIV_STEPS];
    logic [WORD_W-1:0]       wr_word;

    // multiplier operand selection per phase
    assign mul_a = mul_sqr_reg ? base_reg : acc_reg;

    always_comb begin
        unique case (mul_cnt_reg)
            MUL_PH_LL: begin
                mul_x = mul_a[HALF_W-1:0];
                mul_y = base_reg[HALF_W-1:0];
            end
            MUL_PH_LH: begin
                mul_x = mul_a[HALF_W-1:0];
                mul_y = base_reg[WORD_W-1:HALF_W];
            end
            default: begin
                mul_x = mul_a[WORD_W-1:HALF_W];
                mul_y = base_reg[HALF_W-1:0];
            end
        endcase
    end

    // reduced operands fit the low half, so one phase is enough
    assign mul_last = modular_mode ? (mul_cnt_reg == MUL_PH_LL) : (mul_cnt_reg == MUL_PH_HL);
    assign pp_add   = pp_shift_reg ? {pp_reg[HALF_W-1:0], {HALF_W{1'b0}}} : pp_reg;

    // restoring remainder steps, most significant dividend bit first
    always_comb begin
        rem_step[0] = div_rem_reg;
        for (int i = 0; i < DIV_STEPS; i++) begin
            trial[i] = {rem_step[i], div_num_reg[WORD_W-1-i]};
            if (trial[i] >= {1'b0, modulus}) begin
                trial[i] = trial[i] - {1'b0, modulus};
            end
            rem_step[i+1] = trial[i][MODULUS_BITS-1:0];
        end
    end

    assign wr_word = cmd.wr_from_rem ? WORD_W'(div_rem_reg) : prod_reg;

    // sequencing of the multiplier and remainder unit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_busy_reg <= 1'b0;
            mul_cnt_reg  <= MUL_PH_LL;
            pp_valid_reg <= 1'b0;
            mul_done_reg <= 1'b0;
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
            div_done_reg <= 1'b0;
        end else begin
            pp_valid_reg <= mul_busy_reg;
            mul_done_reg <= pp_valid_reg && pp_last_reg;
            if (cmd.mul_start) begin
                mul_busy_reg <= 1'b1;
                mul_cnt_reg  <= MUL_PH_LL;
            end else if (mul_busy_reg) begin
                if (mul_last) begin
                    mul_busy_reg <= 1'b0;
                end else begin
                    mul_cnt_reg <= mul_cnt_reg + MUL_CNT_W'(1);
                end
            end

            div_done_reg <= div_busy_reg && (div_cnt_reg == DIV_CNT_LAST);
            if (cmd.div_start) begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= '0;
            end else if (div_busy_reg) begin
                if (div_cnt_reg == DIV_CNT_LAST) begin
                    div_busy_reg <= 1'b0;
                end else begin
                    div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                end
            end
        end
    end

    // partial products and their accumulation
    always_ff @(posedge aclk) begin
        pp_reg       <= WORD_W'(mul_x) * WORD_W'(mul_y);
        pp_shift_reg <= (mul_cnt_reg != MUL_PH_LL);
        pp_last_reg  <= mul_last;
        if (cmd.mul_start) begin
            mul_sqr_reg <= cmd.mul_sqr;
            prod_reg    <= '0;
        end else if (pp_valid_reg) begin
            prod_reg <= prod_reg + pp_add;
        end
    end

    // remainder unit registers
    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            div_num_reg <= cmd.div_from_prod ? prod_reg : base_reg;
            div_rem_reg <= '0;
        end else if (div_busy_reg) begin
            div_num_reg <= div_num_reg << DIV_STEPS;
            div_rem_reg <= rem_step[DIV_STEPS];
        end
    end

    // operand, accumulator and result registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            base_reg <= in_base;
            exp_reg  <= in_exp;
            acc_reg  <= WORD_W'(1);
        end else begin
            if (cmd.acc_zero) begin
                acc_reg <= '0;
            end
            if (cmd.acc_wr) begin
                acc_reg <= wr_word;
            end
            if (cmd.base_wr) begin
                base_reg <= wr_word;
            end
            if (cmd.exp_shift) begin
                exp_reg <= exp_reg >> 1;
            end
        end
        if (cmd.out_load) begin
            power_reg <= acc_reg;
        end
    end

    assign power = power_reg;

    // status to the controller
    assign status.exp_zero      = (exp_reg == '0);
    assign status.exp_lsb       = exp_reg[0];
    assign status.exp_rest_zero = (exp_reg[EXP_W-1:1] == '0);
    assign status.mod_trivial   = (modulus[MODULUS_BITS-1:1] == '0);
    assign status.modular       = modular_mode;
    assign status.mul_done      = mul_done_reg;
    assign status.div_done      = div_done_reg;

endmodule

/* rtl/mexp_ctrl.sv */
`timescale 1ns / 1ps
// ============================================================================
// mexp_ctrl
// Controller: walks the exponent bits right to left, issuing products and
// reductions to the datapath, and owns both handshakes.
// ============================================================================
module mexp_ctrl import mexp_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    // state and output valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                priority if (status.exp_zero) begin
                    state_next = ST_FINISH;
                end else if (status.modular && status.mod_trivial) begin
                    cmd.acc_zero = 1'b1;
                    state_next   = ST_FINISH;
                end else if (status.modular) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_BASE_RED;
                end else begin
                    state_next = ST_TEST;
                end
            end
            ST_BASE_RED: begin
                if (status.div_done) begin
                    cmd.base_wr     = 1'b1;
                    cmd.wr_from_rem = 1'b1;
                    state_next      = ST_TEST;
                end
            end
            ST_TEST: begin
                priority if (status.exp_zero) begin
                    state_next = ST_FINISH;
                end else if (status.exp_lsb) begin
                    cmd.mul_start = 1'b1;
                    state_next    = ST_MUL;
                end else begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sqr   = 1'b1;
                    state_next    = ST_SQR;
                end
            end
            ST_MUL: begin
                if (status.mul_done) begin
                    if (status.modular) begin
                        cmd.div_start     = 1'b1;
                        cmd.div_from_prod = 1'b1;
                        state_next        = ST_MUL_RED;
                    end else begin
                        cmd.acc_wr = 1'b1;
                        // last set bit: the final square is not needed
                        if (status.exp_rest_zero) begin
                            state_next = ST_FINISH;
                        end else begin
                            cmd.mul_start = 1'b1;
                            cmd.mul_sqr   = 1'b1;
                            state_next    = ST_SQR;
                        end
                    end
                end
            end
            ST_MUL_RED: begin
                if (status.div_done) begin
                    cmd.acc_wr      = 1'b1;
                    cmd.wr_from_rem = 1'b1;
                    if (status.exp_rest_zero) begin
                        state_next = ST_FINISH;
                    end else begin
                        cmd.mul_start = 1'b1;
                        cmd.mul_sqr   = 1'b1;
                        state_next    = ST_SQR;
                    end
                end
            end
            ST_SQR: begin
                if (status.mul_done) begin
                    if (status.modular) begin
                        cmd.div_start     = 1'b1;
                        cmd.div_from_prod = 1'b1;
                        state_next        = ST_SQR_RED;
                    end else begin
                        cmd.base_wr   = 1'b1;
                        cmd.exp_shift = 1'b1;
                        state_next    = ST_TEST;
                    end
                end
            end
            ST_SQR_RED: begin
                if (status.div_done) begin
                    cmd.base_wr     = 1'b1;
                    cmd.wr_from_rem = 1'b1;
                    cmd.exp_shift   = 1'b1;
                    state_next      = ST_TEST;
                end
            end
            ST_FINISH: begin
                // wait for the result register to be free
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

/* rtl/modular_exponentiation.sv */
`timescale 1ns / 1ps
// Modular mode reduces the base first; each product then takes one 32 x 32
// partial product and is reduced on the shared radix-16 remainder unit; plain
// mode builds each product from three 32 x 32 partial products.
// Throughput: one item at a time; the next transfer is taken once the result
// sits in the output register. Reset: synchronous active-low aresetn clears
// control, modulus to 1, modular mode on.
// ============================================================================
// modular_exponentiation
// Right-to-left square-and-multiply exponentiation, reduced by a configured
// modulus or wrapped to 64 bits, with a plain register write port.
// ============================================================================
module modular_exponentiation import mexp_pkg::*; #(
    parameter int MODULUS_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [WORD_W-1:0]     s_base,
    input  logic [EXP_W-1:0]      s_exponent,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [WORD_W-1:0]     m_power,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    logic [MODULUS_BITS-1:0] modulus_reg;
    logic                    modular_mode_reg;
    cmd_t                    cmd;
    status_t                 status;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg      <= MODULUS_BITS'(1);
            modular_mode_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_MODULUS:      modulus_reg      <= cfg_wr_data[MODULUS_BITS-1:0];
                REG_MODULAR_MODE: modular_mode_reg <= cfg_wr_data[0];
            endcase
        end
    end

    mexp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mexp_dp #(
        .MODULUS_BITS (MODULUS_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .in_base      (s_base),
        .in_exp       (s_exponent),
        .modulus      (modulus_reg),
        .modular_mode (modular_mode_reg),
        .power        (m_power)
    );

endmodule
